FILE: sv/bpa_pkg.sv
// Shared constants, types and helper functions of the buddy page allocator.
`default_nettype none
package bpa_pkg;

    localparam int ORDER_COUNT = 11;
    localparam int PAGE_DEPTH  = 4096;
    localparam int PAGE_W      = $clog2(PAGE_DEPTH);
    localparam int LINK_W      = PAGE_W + 1;
    localparam int ORD_W       = $clog2(ORDER_COUNT + 1);
    localparam int OIDX_W      = $clog2(ORDER_COUNT);
    localparam int CNT_W       = 13;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(PAGE_DEPTH);

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_ADD   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_BAD   = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_SEARCH,
        ST_ALLOC_SPLIT,
        ST_FREE_CHK,
        ST_FREE_EV,
        ST_MERGE_RD,
        ST_MERGE_EV,
        ST_MERGE_NEXT,
        ST_FREE_PUSH,
        ST_FREE_DONE,
        ST_ADD_STEP,
        ST_ADD_EV,
        ST_ADD_ADV,
        ST_UNL_RD,
        ST_UNL_WR,
        ST_PUSH_A,
        ST_PUSH_B,
        ST_FINISH
    } state_t;

    // Per-page block header: free-head flag and block order
    typedef struct packed {
        logic             flag;
        logic [ORD_W-1:0] order;
    } hdr_t;

    // Smallest order whose block covers cnt pages (zero counts as one)
    function automatic logic [ORD_W-1:0] order_for(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] c;
        logic [ORD_W-1:0] res;
        logic [CNT_W:0]   sz;
        c   = (cnt == '0) ? CNT_W'(1) : cnt;
        res = ORD_W'(ORDER_COUNT);
        for (int k = ORDER_COUNT - 1; k >= 0; k--)
        begin
            sz = (CNT_W+1)'(1) << k;
            if (sz >= {1'b0, c})
                res = ORD_W'(k);
        end
        return res;
    endfunction

    // Alignment order of a page, capped at the top order
    function automatic logic [ORD_W-1:0] align_order(input logic [PAGE_W-1:0] pos);
        logic [ORD_W-1:0] res;
        res = ORD_W'(ORDER_COUNT - 1);
        for (int a = ORDER_COUNT - 2; a >= 0; a--)
        begin
            if (pos[a])
                res = ORD_W'(a);
        end
        return res;
    endfunction

    // Largest order that fits in remain pages, capped at the top order
    function automatic logic [ORD_W-1:0] fit_order(input logic [CNT_W-1:0] remain);
        logic [ORD_W-1:0] res;
        logic [CNT_W:0]   sz;
        res = '0;
        for (int s = 1; s < ORDER_COUNT; s++)
        begin
            sz = (CNT_W+1)'(1) << s;
            if (sz <= {1'b0, remain})
                res = ORD_W'(s);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: sv/buddy_page_allocator.sv
// Buddy page allocator: request sequencer, free lists and page header memories.
`default_nettype none
// One request enters on the s_ beat and yields exactly one m_ beat. Requests
// are served one at a time by a small sequencer around header and link
// memories with one read and one write port each; s_tready is high only while
// the block is idle. An allocate searches up the orders, unlinks the block,
// pushes each split-off half (also relinking the old head when the lower list
// is not empty) and finishes; a failed allocate searches and finishes. A free
// checks the block (finishing at once when it is rejected), runs its merge
// steps, then pushes the block and finishes. An add-region pushes each carved
// block, skips a block that is already a free head, and finishes; an empty
// region or an unused code finishes at once. The result beat waits while the
// previous one is still held on the m_ side.
// After reset a clearing pass zeroes the header flags of every page before
// the first request is taken; page_limit can be written at any time.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // page_index[11:0], page_count[24:12], zero pad
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // block_index[11:0], block_order[15:12], free_total[28:16]
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [CNT_W-1:0]  page_limit_reg;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [PAGE_W-1:0] clr_cnt_reg;
    logic [ORD_W-1:0]  k_reg, k_next, cur_ord_reg, cur_ord_next, op_ord_reg, op_ord_next;
    logic [PAGE_W-1:0] base_reg, base_next, op_pg_reg, op_pg_next;
    logic [CNT_W-1:0]  pos_reg, pos_next, end_reg, end_next;
    logic [LINK_W-1:0] link_h_reg, link_h_next;
    logic [1:0]        status_reg, status_next;
    logic [PAGE_W-1:0] blk_out_reg, blk_out_next;
    logic [ORD_W-1:0]  ord_out_reg, ord_out_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    logic [LINK_W-1:0] list_head_reg [ORDER_COUNT];
    logic              head_we;
    logic [LINK_W-1:0] head_wdata;

    // Page memories
    hdr_t              hdr_mem  [PAGE_DEPTH];
    logic [LINK_W-1:0] next_mem [PAGE_DEPTH];
    logic [LINK_W-1:0] prev_mem [PAGE_DEPTH];
    hdr_t              hdr_q;
    logic [LINK_W-1:0] next_q, prev_q;
    logic [PAGE_W-1:0] hdr_raddr, hdr_waddr, next_waddr, prev_waddr;
    logic              hdr_we, next_we, prev_we;
    hdr_t              hdr_wdata;
    logic [LINK_W-1:0] next_wdata, prev_wdata;

    logic [CNT_W-1:0]  lim;
    logic [LINK_W-1:0] head_sel;
    logic [PAGE_W-1:0] buddy;
    logic [CNT_W:0]    half, region_end, free_end;
    logic [ORD_W-1:0]  in_k, add_u, add_a, add_s;
    logic              free_bad;

    // APB register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, page_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            page_limit_reg <= CNT_W'(PAGE_DEPTH);
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
            page_limit_reg <= pwdata[CNT_W-1:0];
    end

    assign lim = (page_limit_reg < CNT_W'(PAGE_DEPTH)) ? page_limit_reg : CNT_W'(PAGE_DEPTH);

    // Header memory: flag and order per page
    always_ff @(posedge clk)
    begin
        if (hdr_we)
            hdr_mem[hdr_waddr] <= hdr_wdata;
        hdr_q <= hdr_mem[hdr_raddr];
    end

    // Link memories, both read at the page under work
    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        next_q <= next_mem[op_pg_reg];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        prev_q <= prev_mem[op_pg_reg];
    end

    // List heads, one per order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER_COUNT; i++)
                list_head_reg[i] <= NIL_LINK;
        end
        else
        begin
            for (int i = 0; i < ORDER_COUNT; i++)
            begin
                if (head_we && op_ord_reg == ORD_W'(i))
                    list_head_reg[i] <= head_wdata;
            end
        end
    end

    assign head_sel = (cur_ord_reg < ORD_W'(ORDER_COUNT)) ?
                      list_head_reg[cur_ord_reg[OIDX_W-1:0]] : NIL_LINK;

    // Helper values for the sequencer
    assign in_k       = order_for(s_tdata[24:12]);
    assign region_end = {1'b0, {(CNT_W-PAGE_W){1'b0}}, s_tdata[11:0]} + {1'b0, s_tdata[24:12]};
    assign half       = {1'b0, {(CNT_W-PAGE_W){1'b0}}, base_reg}
                      + ((CNT_W+1)'(1) << (cur_ord_reg - ORD_W'(1)));
    assign free_end   = {1'b0, {(CNT_W-PAGE_W){1'b0}}, base_reg} + ((CNT_W+1)'(1) << k_reg);
    assign buddy      = base_reg ^ PAGE_W'((CNT_W+1)'(1) << cur_ord_reg);
    assign add_a      = align_order(pos_reg[PAGE_W-1:0]);
    assign add_s      = fit_order(end_reg - pos_reg);
    assign add_u      = (add_a < add_s) ? add_a : add_s;
    assign free_bad   = (k_reg >= ORD_W'(ORDER_COUNT))
                     || ((base_reg & ~(PAGE_W'({PAGE_W{1'b1}}) << k_reg)) != '0)
                     || (free_end > (CNT_W+1)'(PAGE_DEPTH))
                     || hdr_q.flag;

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (state_reg == ST_CLEAR)
            clr_cnt_reg <= clr_cnt_reg + PAGE_W'(1);
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ret_reg      <= ST_IDLE;
            free_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            ret_reg      <= ret_next;
            free_cnt_reg <= free_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        cur_ord_reg <= cur_ord_next;
        op_ord_reg  <= op_ord_next;
        base_reg    <= base_next;
        op_pg_reg   <= op_pg_next;
        pos_reg     <= pos_next;
        end_reg     <= end_next;
        link_h_reg  <= link_h_next;
        status_reg  <= status_next;
        blk_out_reg <= blk_out_next;
        ord_out_reg <= ord_out_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    // Sequencer: next state, memory and list updates
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        free_cnt_next = free_cnt_reg;
        k_next        = k_reg;
        cur_ord_next  = cur_ord_reg;
        op_ord_next   = op_ord_reg;
        base_next     = base_reg;
        op_pg_next    = op_pg_reg;
        pos_next      = pos_reg;
        end_next      = end_reg;
        link_h_next   = link_h_reg;
        status_next   = status_reg;
        blk_out_next  = blk_out_reg;
        ord_out_next  = ord_out_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        head_we       = 1'b0;
        head_wdata    = NIL_LINK;
        hdr_we        = 1'b0;
        hdr_waddr     = op_pg_reg;
        hdr_wdata     = '0;
        hdr_raddr     = op_pg_reg;
        next_we       = 1'b0;
        next_waddr    = op_pg_reg;
        next_wdata    = NIL_LINK;
        prev_we       = 1'b0;
        prev_waddr    = op_pg_reg;
        prev_wdata    = NIL_LINK;
        s_tready      = 1'b0;

        // Drop the result beat once taken
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                hdr_we    = 1'b1;
                hdr_waddr = clr_cnt_reg;
                if (clr_cnt_reg == PAGE_W'(PAGE_DEPTH - 1))
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    status_next  = STAT_DONE;
                    blk_out_next = '0;
                    ord_out_next = '0;
                    k_next       = in_k;
                    cur_ord_next = in_k;
                    base_next    = s_tdata[11:0];
                    pos_next     = {{(CNT_W-PAGE_W){1'b0}}, s_tdata[11:0]};
                    end_next     = (region_end > (CNT_W+1)'(PAGE_DEPTH)) ?
                                   CNT_W'(PAGE_DEPTH) : region_end[CNT_W-1:0];
                    case (s_tuser)
                        REQ_ALLOC: state_next = ST_ALLOC_SEARCH;
                        REQ_FREE:  state_next = ST_FREE_CHK;
                        REQ_ADD:
                        begin
                            if (s_tdata[24:12] == '0)
                            begin
                                status_next = STAT_BAD;
                                state_next  = ST_FINISH;
                            end
                            else
                                state_next = ST_ADD_STEP;
                        end
                        default:
                        begin
                            status_next = STAT_BAD;
                            state_next  = ST_FINISH;
                        end
                    endcase
                end
            end

            // Walk up the orders to the first non-empty list
            ST_ALLOC_SEARCH:
            begin
                if (cur_ord_reg >= ORD_W'(ORDER_COUNT))
                begin
                    status_next = STAT_NOFIT;
                    state_next  = ST_FINISH;
                end
                else if (head_sel == NIL_LINK)
                    cur_ord_next = cur_ord_reg + ORD_W'(1);
                else
                begin
                    base_next   = head_sel[PAGE_W-1:0];
                    op_pg_next  = head_sel[PAGE_W-1:0];
                    op_ord_next = cur_ord_reg;
                    ret_next    = ST_ALLOC_SPLIT;
                    state_next  = ST_UNL_RD;
                end
            end

            // Push split-off upper halves down to the wanted order
            ST_ALLOC_SPLIT:
            begin
                if (cur_ord_reg > k_reg)
                begin
                    cur_ord_next = cur_ord_reg - ORD_W'(1);
                    if (half < (CNT_W+1)'(PAGE_DEPTH))
                    begin
                        op_pg_next  = half[PAGE_W-1:0];
                        op_ord_next = cur_ord_reg - ORD_W'(1);
                        ret_next    = ST_ALLOC_SPLIT;
                        state_next  = ST_PUSH_A;
                    end
                end
                else
                begin
                    free_cnt_next = free_cnt_reg - (CNT_W'(1) << k_reg);
                    blk_out_next  = base_reg;
                    ord_out_next  = k_reg;
                    state_next    = ST_FINISH;
                end
            end

            ST_FREE_CHK:
            begin
                hdr_raddr  = base_reg;
                state_next = ST_FREE_EV;
            end

            ST_FREE_EV:
            begin
                if (free_bad)
                begin
                    status_next = STAT_BAD;
                    state_next  = ST_FINISH;
                end
                else
                    state_next = ST_MERGE_RD;
            end

            // Look up the buddy at the current order
            ST_MERGE_RD:
            begin
                hdr_raddr = buddy;
                if (cur_ord_reg + ORD_W'(1) < ORD_W'(ORDER_COUNT)
                    && {{(CNT_W-PAGE_W){1'b0}}, buddy} < lim)
                begin
                    op_pg_next = buddy;
                    state_next = ST_MERGE_EV;
                end
                else
                    state_next = ST_FREE_PUSH;
            end

            ST_MERGE_EV:
            begin
                if (hdr_q.flag && hdr_q.order == cur_ord_reg)
                begin
                    op_ord_next = cur_ord_reg;
                    ret_next    = ST_MERGE_NEXT;
                    state_next  = ST_UNL_RD;
                end
                else
                    state_next = ST_FREE_PUSH;
            end

            ST_MERGE_NEXT:
            begin
                if (op_pg_reg < base_reg)
                    base_next = op_pg_reg;
                cur_ord_next = cur_ord_reg + ORD_W'(1);
                state_next   = ST_MERGE_RD;
            end

            ST_FREE_PUSH:
            begin
                op_pg_next  = base_reg;
                op_ord_next = cur_ord_reg;
                ret_next    = ST_FREE_DONE;
                state_next  = ST_PUSH_A;
            end

            ST_FREE_DONE:
            begin
                free_cnt_next = free_cnt_reg + (CNT_W'(1) << k_reg);
                ord_out_next  = cur_ord_reg;
                state_next    = ST_FINISH;
            end

            // Carve the region into aligned blocks
            ST_ADD_STEP:
            begin
                hdr_raddr = pos_reg[PAGE_W-1:0];
                if (pos_reg >= end_reg)
                    state_next = ST_FINISH;
                else
                begin
                    op_pg_next  = pos_reg[PAGE_W-1:0];
                    op_ord_next = add_u;
                    state_next  = ST_ADD_EV;
                end
            end

            ST_ADD_EV:
            begin
                if (!hdr_q.flag)
                begin
                    free_cnt_next = free_cnt_reg + (CNT_W'(1) << op_ord_reg);
                    ret_next      = ST_ADD_ADV;
                    state_next    = ST_PUSH_A;
                end
                else
                    state_next = ST_ADD_ADV;
            end

            ST_ADD_ADV:
            begin
                pos_next   = pos_reg + (CNT_W'(1) << op_ord_reg);
                state_next = ST_ADD_STEP;
            end

            // Unlink op_pg from list op_ord and clear its header
            ST_UNL_RD:
            begin
                state_next = ST_UNL_WR;
            end

            ST_UNL_WR:
            begin
                hdr_we = 1'b1;
                if (prev_q != NIL_LINK)
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_q[PAGE_W-1:0];
                    next_wdata = next_q;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = next_q;
                end
                if (next_q != NIL_LINK)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_q[PAGE_W-1:0];
                    prev_wdata = prev_q;
                end
                state_next = ret_reg;
            end

            // Push op_pg onto list op_ord as a free head
            ST_PUSH_A:
            begin
                hdr_we          = 1'b1;
                hdr_wdata.flag  = 1'b1;
                hdr_wdata.order = op_ord_reg;
                next_we         = 1'b1;
                next_wdata      = list_head_reg[op_ord_reg[OIDX_W-1:0]];
                prev_we         = 1'b1;
                head_we         = 1'b1;
                head_wdata      = {1'b0, op_pg_reg};
                link_h_next     = list_head_reg[op_ord_reg[OIDX_W-1:0]];
                if (list_head_reg[op_ord_reg[OIDX_W-1:0]] != NIL_LINK)
                    state_next = ST_PUSH_B;
                else
                    state_next = ret_reg;
            end

            ST_PUSH_B:
            begin
                prev_we    = 1'b1;
                prev_waddr = link_h_reg[PAGE_W-1:0];
                prev_wdata = {1'b0, op_pg_reg};
                state_next = ret_reg;
            end

            // Hand the result to the output register once it is free
            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {{(32-CNT_W-ORD_W-PAGE_W){1'b0}}, free_cnt_reg,
                                    ord_out_reg, blk_out_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTH
    // One request at a time: ready drops after each accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // Splitting never goes below the requested order
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC_SPLIT) |-> (cur_ord_reg >= k_reg))
        else $error("split below requested order");

    // Result status is always a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STAT_DONE || m_tuser == STAT_NOFIT || m_tuser == STAT_BAD))
        else $error("undefined result status");
`endif

endmodule
`default_nettype wire

FILE: tb/buddy_page_allocator_test.sv
// Self-checking testbench of the buddy page allocator: directed table, then random traffic.
`timescale 1ns / 100ps
module buddy_page_allocator_test;
    import bpa_pkg::*;

    localparam logic [1:0] REQ_UNUSED      = 2'd3;
    localparam logic [2:0] ADDR_PAGE_LIMIT = 3'd0;
    localparam int         IDLE_LIMIT      = 40000;
    localparam int         PAGES           = 4096;
    localparam int         ORDERS          = 11;
    localparam int         NO_LINK         = 4096;

    typedef struct {
        status_t     st;
        logic [11:0] blk;
        logic [3:0]  ord;
        logic [12:0] total;
    } reply_t;

    typedef struct {
        logic [1:0]  rq;
        logic [11:0] pidx;
        logic [12:0] pcnt;
        bit          typed;
        reply_t      want;
    } row_t;

    typedef struct {
        int pg;
        int ord;
    } held_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // page_index[11:0], page_count[24:12], zero pad
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // block_index[11:0], block_order[15:12], free_total[28:16]
    logic [1:0]  m_tuser;   // status[1:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow allocator state
    bit     page_is_head [PAGES];
    int     page_order [PAGES];
    int     link_next [PAGES];
    int     link_prev [PAGES];
    int     order_head [ORDERS];
    int     order_len [ORDERS];
    int     pages_free;
    int     limit_pages;

    reply_t expected_replies [$];
    held_t  granted_blocks [$];
    int     errors;
    int     items_sent;
    int     replies_seen;
    int     grants;
    int     limits_tried;
    int     idle_cycles;
    int     burst_left;

    buddy_page_allocator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, want %0d (reply %0d)", what, got, want, replies_seen);
        errors++;
    endtask

    function automatic int round_order(input int cnt);
        int c;
        int k;
        c = (cnt == 0) ? 1 : cnt;
        k = 0;
        while ((1 << k) < c && k < ORDERS)
            k++;
        return k;
    endfunction

    function automatic void list_insert(input int o, input int pg);
        link_next[pg] = order_head[o];
        link_prev[pg] = NO_LINK;
        if (order_head[o] < NO_LINK)
            link_prev[order_head[o]] = pg;
        order_head[o] = pg;
        order_len[o] = (order_len[o] + 1) & 13'h1fff;
    endfunction

    function automatic void list_drop(input int o, input int pg);
        int p;
        int n;
        p = link_prev[pg];
        n = link_next[pg];
        if (p < NO_LINK)
            link_next[p] = n;
        else
            order_head[o] = n;
        if (n < NO_LINK)
            link_prev[n] = p;
        order_len[o] = (order_len[o] - 1) & 13'h1fff;
    endfunction

    // Work out the reply to one request and advance the shadow state
    function automatic reply_t serve_request(input logic [1:0] rq, input int pidx,
                                             input int pcnt);
        reply_t r;
        int k;
        int f;
        int blk;
        int base;
        int o;
        int b;
        int lim;
        int stop;
        int pos;
        int a;
        int s;
        int u;
        r.st = STAT_DONE;
        r.blk = '0;
        r.ord = '0;
        if (rq == REQ_ALLOC)
        begin
            k = round_order(pcnt);
            f = k;
            while (f < ORDERS && order_head[f] == NO_LINK)
                f++;
            if (f >= ORDERS)
                r.st = STAT_NOFIT;
            else
            begin
                blk = order_head[f];
                list_drop(f, blk);
                page_is_head[blk] = 0;
                // Hand the split-off upper halves back to the lower lists
                while (f > k)
                begin
                    f--;
                    if (blk + (1 << f) < PAGES)
                    begin
                        page_is_head[blk + (1 << f)] = 1;
                        page_order[blk + (1 << f)] = f;
                        list_insert(f, blk + (1 << f));
                    end
                end
                pages_free = (pages_free - (1 << k)) & 13'h1fff;
                r.blk = blk[11:0];
                r.ord = k[3:0];
            end
        end
        else if (rq == REQ_FREE)
        begin
            k = round_order(pcnt);
            if (k >= ORDERS || (pidx & ((1 << k) - 1)) != 0 || pidx + (1 << k) > PAGES
                || page_is_head[pidx])
                r.st = STAT_BAD;
            else
            begin
                base = pidx;
                o = k;
                lim = (limit_pages < PAGES) ? limit_pages : PAGES;
                // Merge with free buddies of equal order below the limit
                while (o + 1 < ORDERS)
                begin
                    b = base ^ (1 << o);
                    if (b < lim && page_is_head[b] && page_order[b] == o)
                    begin
                        list_drop(o, b);
                        page_is_head[b] = 0;
                        if (b < base)
                            base = b;
                        o++;
                    end
                    else
                        break;
                end
                page_is_head[base] = 1;
                page_order[base] = o;
                list_insert(o, base);
                pages_free = (pages_free + (1 << k)) & 13'h1fff;
                r.ord = o[3:0];
            end
        end
        else if (rq == REQ_ADD)
        begin
            if (pcnt == 0)
                r.st = STAT_BAD;
            else
            begin
                stop = (pidx + pcnt > PAGES) ? PAGES : pidx + pcnt;
                pos = pidx;
                // Carve the region into aligned power-of-two blocks
                while (pos < stop)
                begin
                    a = 0;
                    s = 0;
                    while (a < ORDERS - 1 && ((pos >> a) & 1) == 0)
                        a++;
                    while (s < ORDERS - 1 && (2 << s) <= stop - pos)
                        s++;
                    u = (a < s) ? a : s;
                    if (!page_is_head[pos])
                    begin
                        page_is_head[pos] = 1;
                        page_order[pos] = u;
                        list_insert(u, pos);
                        pages_free = (pages_free + (1 << u)) & 13'h1fff;
                    end
                    pos += 1 << u;
                end
            end
        end
        else
            r.st = STAT_BAD;
        r.total = pages_free[12:0];
        return r;
    endfunction

    // Offer one request beat, with a random gap between bursts
    task automatic send(input logic [1:0] rq, input logic [11:0] pidx, input logic [12:0] pcnt,
                        input bit typed, input reply_t want);
        reply_t r;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= rq;
        s_tdata <= {7'b0, pcnt, pidx};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        r = serve_request(rq, pidx, pcnt);
        if (r.st == STAT_DONE && rq == REQ_ALLOC)
        begin
            granted_blocks.push_back('{int'(r.blk), int'(r.ord)});
            grants++;
        end
        expected_replies.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Write page_limit over the APB port and read it back
    task automatic set_page_limit(input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_PAGE_LIMIT;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[12:0] != 13'(value))
            report("page_limit readback", prdata[12:0], value);
        psel <= 1'b0;
        penable <= 1'b0;
        limit_pages = value & 13'h1fff;
        limits_tried++;
    endtask

    task automatic random_phase(input int n);
        held_t h;
        int pick;
        int sel;
        int k;
        reply_t none;
        none = '{STAT_DONE, '0, '0, '0};
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send(REQ_ALLOC, 12'($urandom),
                     ($urandom_range(0, 9) < 7) ? 13'($urandom_range(0, 16))
                     : ($urandom_range(0, 9) == 0 ? 13'd4096 : 13'($urandom_range(0, 1024))),
                     0, none);
            else if (pick < 70 && granted_blocks.size() != 0)
            begin
                // Return a block held earlier, with a count that rounds to its order
                sel = $urandom_range(0, granted_blocks.size() - 1);
                h = granted_blocks[sel];
                granted_blocks.delete(sel);
                k = h.ord;
                send(REQ_FREE, 12'(h.pg),
                     13'(k == 0 ? $urandom_range(0, 1)
                         : $urandom_range((1 << (k - 1)) + 1, 1 << k)), 0, none);
            end
            else if (pick < 82)
                send(REQ_ADD, 12'($urandom_range(0, 4095)),
                     ($urandom_range(0, 7) == 0) ? 13'($urandom_range(1, 4096))
                     : 13'($urandom_range(1, 64)), 0, none);
            else
                send(2'($urandom), 12'($urandom), 13'($urandom_range(0, 4096)), 0, none);
        end
    endtask

    // Receiver stalls in stretches: ready throughout, or randomly
    int stall_mode;
    int stall_left;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        m_tready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        reply_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            replies_seen++;
            if (expected_replies.size() == 0)
                report("unexpected beat", m_tuser, -1);
            else
            begin
                w = expected_replies.pop_front();
                if (m_tuser != w.st)
                    report("status", m_tuser, w.st);
                if (m_tdata[11:0] != w.blk)
                    report("block_index", m_tdata[11:0], w.blk);
                if (m_tdata[15:12] != w.ord)
                    report("block_order", m_tdata[15:12], w.ord);
                if (m_tdata[28:16] != w.total)
                    report("free_total", m_tdata[28:16], w.total);
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    row_t directed [] = '{
        // Fresh after reset: nothing free, a bad code, an empty add and oversize or misaligned frees
        '{REQ_ALLOC,  12'd0,    13'd0,    1, '{STAT_NOFIT, 12'd0, 4'd0, 13'd0}},
        '{REQ_UNUSED, 12'hfff,  13'h1000, 1, '{STAT_BAD,   12'd0, 4'd0, 13'd0}},
        '{REQ_ADD,    12'd5,    13'd0,    1, '{STAT_BAD,   12'd0, 4'd0, 13'd0}},
        '{REQ_FREE,   12'd0,    13'd4096, 1, '{STAT_BAD,   12'd0, 4'd0, 13'd0}},
        '{REQ_FREE,   12'd0,    13'd1025, 1, '{STAT_BAD,   12'd0, 4'd0, 13'd0}},
        '{REQ_FREE,   12'd1,    13'd2,    1, '{STAT_BAD,   12'd0, 4'd0, 13'd0}},
        // Fill, split, merge and clip
        '{REQ_ADD,    12'd0,    13'd4096, 0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_ALLOC,  12'd0,    13'd1,    0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_ALLOC,  12'd0,    13'd3,    0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_ALLOC,  12'd0,    13'd1024, 0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_ALLOC,  12'd0,    13'd4096, 0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_ALLOC,  12'd0,    13'd2048, 0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_FREE,   12'd0,    13'd0,    0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_FREE,   12'd4,    13'd4,    0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_FREE,   12'd0,    13'd1,    0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_FREE,   12'd1024, 13'd1024, 0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_ADD,    12'd4095, 13'd4096, 0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_ADD,    12'd7,    13'd4096, 0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_FREE,   12'd4094, 13'd2,    0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_ALLOC,  12'hfff,  13'd1024, 0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_ALLOC,  12'd0,    13'd513,  0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}},
        '{REQ_UNUSED, 12'd0,    13'd0,    0, '{STAT_DONE,  12'd0, 4'd0, 13'd0}}
    };

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_left = 0;
        stall_mode = 0;
        idle_cycles = 0;
        errors = 0;
        items_sent = 0;
        replies_seen = 0;
        grants = 0;
        limits_tried = 0;
        burst_left = 0;
        pages_free = 0;
        limit_pages = 4096;
        for (int i = 0; i < PAGES; i++)
            page_is_head[i] = 0;
        for (int i = 0; i < ORDERS; i++)
        begin
            order_head[i] = NO_LINK;
            order_len[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send(directed[i].rq, directed[i].pidx, directed[i].pcnt, directed[i].typed,
                 directed[i].want);
        drain();

        // Sweep the merge limit across its extremes and a random point
        set_page_limit(1);
        random_phase(250);
        drain();
        set_page_limit(4096);
        random_phase(250);
        drain();
        set_page_limit($urandom_range(1, 4096));
        random_phase(250);
        drain();

        $display("sent %0d requests (%0d allocations granted), checked %0d replies",
                 items_sent, grants, replies_seen);
        $display("page_limit settings tried: %0d, mismatches: %0d", limits_tried, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/bpa_pkg.sv
sv/buddy_page_allocator.sv
tb/buddy_page_allocator_test.sv
